FILE: hw/rtl/rgbmf_pkg.sv
// ----------------------------------------------------------------------------
// RGB median filter package
// Shared constants and types of the 5x5 RGB median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbmf_pkg;

    // Default build configuration.
    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_WINDOW_SIZE = 5;
    localparam int DEF_SAMPLE_BITS = 16;

    // Width of one sample on the stream ports.
    localparam int FIELD_BITS = 16;

    // Width of the image size registers and their reset values.
    localparam int CFG_BITS = 12;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 12'd2048;

    // Largest padded image height.
    localparam int HEIGHT_LIMIT = 4095;

    // Configuration bus.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index (byte address divided by four).
    typedef enum logic [0:0] {
        REG_PADDED_WIDTH  = 1'b0,
        REG_PADDED_HEIGHT = 1'b1
    } reg_index_t;

    // Stage enables of the median pipeline.
    typedef struct packed {
        logic cmp;
        logic rank;
        logic sel;
    } median_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_median_filter_5x5_core.sv
// ----------------------------------------------------------------------------
// RGB median filter core
// Streaming WINDOW_SIZE x WINDOW_SIZE median filter on RGB pixels.
//
// Pixels of a padded image enter on the s_ channel in raster order, one per
// transaction; s_tuser marks the first pixel of a frame. Once the window lies
// fully inside the image, each pixel gives one result transaction on the m_
// channel with the median of each channel; m_tlast marks the last result of
// the frame. Pixels on the top rows and left columns give no result.
// The image size is set over the APB port (width at 0x0, height at 0x4); the user
// must set it only while the core is idle, which the core itself does not enforce.
// Throughput is one pixel per clock while the receiver does not stall. A result
// passes through five register stages: line RAM read, window shift, compare,
// rank, select.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// then holds s_tready low until the output register frees.
// Reset clears the counters, the window and the pipeline valid flags and sets
// both size registers to 2048; the line RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_median_filter_5x5_core #(
    parameter int MAX_WIDTH   = rgbmf_pkg::DEF_MAX_WIDTH,
    parameter int WINDOW_SIZE = rgbmf_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = rgbmf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input pixels.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // frame_start
    // Result pixels.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // red_median, green_median, blue_median
    output logic             m_tlast,   // frame_end
    // Configuration.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [rgbmf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [rgbmf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [rgbmf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic             pready
);

    localparam int FB    = rgbmf_pkg::FIELD_BITS;
    localparam int CB    = rgbmf_pkg::CFG_BITS;
    localparam int N     = WINDOW_SIZE * WINDOW_SIZE;
    localparam int LINES = WINDOW_SIZE - 1;
    localparam int LW    = 3 * SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int WB    = (CW > CB) ? CW : CB;
    localparam int RW    = CB;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CB-1:0] width_cfg_reg;
    logic [CB-1:0] height_cfg_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= rgbmf_pkg::CFG_RESET;
            height_cfg_reg <= rgbmf_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            case (rgbmf_pkg::reg_index_t'(paddr[2]))
                rgbmf_pkg::REG_PADDED_WIDTH:  width_cfg_reg  <= pwdata[CB-1:0];
                rgbmf_pkg::REG_PADDED_HEIGHT: height_cfg_reg <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (rgbmf_pkg::reg_index_t'(paddr[2]))
            rgbmf_pkg::REG_PADDED_WIDTH:
                prdata = {{(rgbmf_pkg::APB_DATA_BITS-CB){1'b0}}, width_cfg_reg};
            rgbmf_pkg::REG_PADDED_HEIGHT:
                prdata = {{(rgbmf_pkg::APB_DATA_BITS-CB){1'b0}}, height_cfg_reg};
            default: prdata = '0;
        endcase
    end

    // Sizes saturated into their legal ranges.
    logic [WB-1:0] width_c;
    logic [RW-1:0] height_c;

    always_comb begin
        if (WB'(width_cfg_reg) < WB'(WINDOW_SIZE)) begin
            width_c = WB'(WINDOW_SIZE);
        end else if (WB'(width_cfg_reg) > WB'(MAX_WIDTH)) begin
            width_c = WB'(MAX_WIDTH);
        end else begin
            width_c = WB'(width_cfg_reg);
        end
        if (height_cfg_reg < RW'(WINDOW_SIZE)) begin
            height_c = RW'(WINDOW_SIZE);
        end else begin
            height_c = height_cfg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic v1_reg, vw_reg, vc_reg, vr_reg;
    logic ready_w, ready_c, ready_r, ready_o;
    logic s1_adv, adv_w, adv_c, adv_r;
    logic s_acc;

    assign ready_o  = !m_tvalid || m_tready;
    assign adv_r    = vr_reg && ready_o;
    assign ready_r  = !vr_reg || ready_o;
    assign adv_c    = vc_reg && ready_r;
    assign ready_c  = !vc_reg || ready_r;
    assign adv_w    = vw_reg && ready_c;
    assign ready_w  = !vw_reg || ready_c;
    assign s1_adv   = v1_reg && ready_w;
    assign s_tready = !v1_reg || ready_w;
    assign s_acc    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [AW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [AW-1:0] col_a;
    logic [RW-1:0] row_a;
    logic          emit_a, last_a, col_end, row_end;

    always_comb begin
        col_a = s_tuser ? '0 : col_cnt_reg;
        row_a = s_tuser ? '0 : row_cnt_reg;
        if (WB'(col_a) >= width_c) begin
            col_a = '0;
        end
        if (row_a >= height_c) begin
            row_a = '0;
        end
        col_end = (WB'(col_a) + WB'(1)) >= width_c;
        row_end = ({1'b0, row_a} + (RW+1)'(1)) >= {1'b0, height_c};
        emit_a  = (row_a >= RW'(WINDOW_SIZE - 1)) && (col_a >= AW'(WINDOW_SIZE - 1));
        last_a  = col_end && row_end;
        if (col_end) begin
            col_cnt_next = '0;
            row_cnt_next = row_end ? '0 : row_a + RW'(1);
        end else begin
            col_cnt_next = col_a + AW'(1);
            row_cnt_next = row_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_acc) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: pixel register alongside the line RAM read
    // ------------------------------------------------------------------
    logic [LW-1:0] px_a;
    logic [LW-1:0] px1_reg;
    logic [AW-1:0] col1_reg;
    logic          emit1_reg, last1_reg;

    for (genvar ch = 0; ch < 3; ch++) begin : g_px
        if (SAMPLE_BITS <= FB) begin : g_narrow
            assign px_a[ch*SAMPLE_BITS +: SAMPLE_BITS] =
                s_tdata[ch*FB +: SAMPLE_BITS];
        end else begin : g_wide
            assign px_a[ch*SAMPLE_BITS +: SAMPLE_BITS] =
                {{(SAMPLE_BITS-FB){1'b0}}, s_tdata[ch*FB +: FB]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_acc) begin
            v1_reg <= 1'b1;
        end else if (s1_adv) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            px1_reg   <= px_a;
            col1_reg  <= col_a;
            emit1_reg <= emit_a;
            last1_reg <= last_a;
        end
    end

    // ------------------------------------------------------------------
    // Line RAMs, oldest line first
    // ------------------------------------------------------------------
    logic [LW-1:0] rd_q [LINES];
    logic [LW-1:0] column [WINDOW_SIZE];
    logic [LW-1:0] byp_data_reg [LINES];
    logic          byp_reg;
    logic          byp_hit;

    // A frame start may put a pixel on the column just written.
    assign byp_hit = s1_adv && (col1_reg == col_a);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (s_acc) begin
            byp_reg <= byp_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int l = 0; l < LINES; l++) begin
                byp_data_reg[l] <= column[l+1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LINES; l++) begin
            column[l] = byp_reg ? byp_data_reg[l] : rd_q[l];
        end
        column[LINES] = px1_reg;
    end

    for (genvar l = 0; l < LINES; l++) begin : g_line
        rgbmf_ram #(
            .WIDTH(LW),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .clk  (aclk),
            .we   (s1_adv),
            .waddr(col1_reg),
            .wdata(column[l+1]),
            .re   (s_acc),
            .raddr(col_a),
            .rdata(rd_q[l])
        );
    end

    // ------------------------------------------------------------------
    // Window: shifts left with the new column entering at the right
    // ------------------------------------------------------------------
    logic [LW-1:0] win_reg [N];
    logic          lastw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int r = 0; r < WINDOW_SIZE; r++) begin
                for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
                    win_reg[r*WINDOW_SIZE + c] <= win_reg[r*WINDOW_SIZE + c + 1];
                end
                win_reg[r*WINDOW_SIZE + WINDOW_SIZE - 1] <= column[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            lastw_reg <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Median pipeline valid flags
    // ------------------------------------------------------------------
    logic lastc_reg, lastr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vr_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (s1_adv) begin
                vw_reg <= emit1_reg;
            end else if (adv_w) begin
                vw_reg <= 1'b0;
            end
            if (adv_w) begin
                vc_reg <= 1'b1;
            end else if (adv_c) begin
                vc_reg <= 1'b0;
            end
            if (adv_c) begin
                vr_reg <= 1'b1;
            end else if (adv_r) begin
                vr_reg <= 1'b0;
            end
            if (adv_r) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_w) begin
            lastc_reg <= lastw_reg;
        end
        if (adv_c) begin
            lastr_reg <= lastc_reg;
        end
        if (adv_r) begin
            m_tlast <= lastr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel medians
    // ------------------------------------------------------------------
    rgbmf_pkg::median_en_t med_en;
    logic [N*SAMPLE_BITS-1:0] win_ch [3];
    logic [SAMPLE_BITS-1:0]   med_ch [3];

    assign med_en.cmp  = adv_w;
    assign med_en.rank = adv_c;
    assign med_en.sel  = adv_r;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        for (genvar k = 0; k < N; k++) begin : g_tap
            assign win_ch[ch][k*SAMPLE_BITS +: SAMPLE_BITS] =
                win_reg[k][ch*SAMPLE_BITS +: SAMPLE_BITS];
        end

        rgbmf_median #(
            .WINDOW_SIZE(WINDOW_SIZE),
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_median (
            .aclk  (aclk),
            .en    (med_en),
            .win   (win_ch[ch]),
            .median(med_ch[ch])
        );

        if (SAMPLE_BITS >= FB) begin : g_out_narrow
            assign m_tdata[ch*FB +: FB] = med_ch[ch][FB-1:0];
        end else begin : g_out_wide
            assign m_tdata[ch*FB +: FB] =
                {{(FB-SAMPLE_BITS){1'b0}}, med_ch[ch]};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A pixel on the column being written picks up the bypass data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && byp_hit) |=> byp_reg)
        else $error("line RAM bypass missed");

    // A frame start lands at column zero and gives no result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (!emit1_reg && col1_reg == '0))
        else $error("frame start not at column zero");

    // A new result only follows a filled rank stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vr_reg))
        else $error("result without rank stage");

    // The compare stage is only loaded from a valid window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vc_reg) |-> $past(vw_reg))
        else $error("compare stage loaded without window");

endmodule

`default_nettype wire

FILE: hw/rtl/rgbmf_ram.sv
// ----------------------------------------------------------------------------
// RGB median filter line RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbmf_median.sv
// ----------------------------------------------------------------------------
// RGB median filter window median
// Three-stage rank-select median of one channel's window.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmf_median #(
    parameter int WINDOW_SIZE = rgbmf_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = rgbmf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                    aclk,
    input  wire rgbmf_pkg::median_en_t   en,
    input  wire logic [WINDOW_SIZE*WINDOW_SIZE*SAMPLE_BITS-1:0] win,
    output logic      [SAMPLE_BITS-1:0]  median
);

    localparam int N    = WINDOW_SIZE * WINDOW_SIZE;
    localparam int RANK = N / 2;
    localparam int RB   = $clog2(N);

    logic [SAMPLE_BITS-1:0] val_c_reg [N];
    logic [N-1:0]           pre_c_reg [N];
    logic [SAMPLE_BITS-1:0] val_r_reg [N];
    logic [RB-1:0]          rank_r_reg [N];
    logic [N-1:0]           pre_next [N];
    logic [RB-1:0]          rank_next [N];
    logic [SAMPLE_BITS-1:0] median_next;

    // Element j precedes element i in the stable sorted order.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                if (j < i) begin
                    pre_next[i][j] = win[j*SAMPLE_BITS +: SAMPLE_BITS]
                                     <= win[i*SAMPLE_BITS +: SAMPLE_BITS];
                end else if (j > i) begin
                    pre_next[i][j] = win[j*SAMPLE_BITS +: SAMPLE_BITS]
                                     < win[i*SAMPLE_BITS +: SAMPLE_BITS];
                end else begin
                    pre_next[i][j] = 1'b0;
                end
            end
        end
    end

    // Compare stage.
    always_ff @(posedge aclk) begin
        if (en.cmp) begin
            for (int i = 0; i < N; i++) begin
                val_c_reg[i] <= win[i*SAMPLE_BITS +: SAMPLE_BITS];
                pre_c_reg[i] <= pre_next[i];
            end
        end
    end

    // The rank of each element is the number of elements that precede it.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            rank_next[i] = '0;
            for (int j = 0; j < N; j++) begin
                rank_next[i] = rank_next[i] + RB'(pre_c_reg[i][j]);
            end
        end
    end

    // Rank stage.
    always_ff @(posedge aclk) begin
        if (en.rank) begin
            for (int i = 0; i < N; i++) begin
                val_r_reg[i]  <= val_c_reg[i];
                rank_r_reg[i] <= rank_next[i];
            end
        end
    end

    // Exactly one element holds the middle rank.
    always_comb begin
        median_next = '0;
        for (int i = 0; i < N; i++) begin
            if (rank_r_reg[i] == RB'(RANK)) begin
                median_next = median_next | val_r_reg[i];
            end
        end
    end

    // Select stage.
    always_ff @(posedge aclk) begin
        if (en.sel) begin
            median <= median_next;
        end
    end

endmodule

`default_nettype wire
